@@ rtl/assert_macros.svh @@
// Assertion helpers, clocked on clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/dbs_pkg.sv @@
package dbs_pkg;

	localparam int MAX_WIDTH_DEF  = 128;
	localparam int MAX_HEIGHT_DEF = 128;
	localparam int MAX_KERNEL_DEF = 8;
	localparam int FRAC_BITS_DEF  = 8;

	localparam int MASK_FRAC  = 15;
	localparam int PIX_W      = 16;
	localparam int DIM_W      = 11;
	localparam int FRAC_MAX   = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int MID_DEPTH  = 4;
	localparam int OUT_DEPTH  = 8;

	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE_R   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE_C   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_R      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_C      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DIL_R      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DIL_C      = 3'd7;

	typedef struct packed {
		logic [7:0] map_width;
		logic [7:0] map_height;
		logic [3:0] stride_rows;
		logic [3:0] stride_cols;
		logic [3:0] pad_rows;
		logic [3:0] pad_cols;
		logic [3:0] dilation_rows;
		logic [3:0] dilation_cols;
	} config_t;

	// write: r_idx/c_idx are the pixel position
	// sample: r_idx/c_idx are floor(point)+1 per axis
	typedef struct packed {
		logic                    is_sample;
		logic                    in_box;
		logic [DIM_W-1:0]        r_idx;
		logic [DIM_W-1:0]        c_idx;
		logic [FRAC_MAX-1:0]     lh;
		logic [FRAC_MAX-1:0]     lw;
		logic [3:0]              nb_ok;
		logic signed [PIX_W-1:0] pixel;
		logic [15:0]             mask;
		logic                    use_mask;
	} entry_t;

	typedef struct packed {
		logic signed [PIX_W-1:0] value;
		logic                    in_box;
	} result_t;

endpackage

@@ rtl/deformable_bilinear_sampler_core.sv @@
// channel   direction  handshake             payload
// input     in         push / full           kind row col tap_row tap_col pixel_value
//                                            offset_rows offset_cols mask_weight use_mask
// result    out        empty / pop           sample_value inside_res
// config    in         cfg_valid / cfg_ready cfg_index cfg_data
//
// One request per cycle sustained while the result queue has room; a sample's result
// shows on the result ports after the request queue, bank read, four arithmetic
// stages and result queue. The store sits in four single-port banks split by row and
// column parity, so a sample's four neighbours are read together. No clearing pass.
// full rises when the 4-entry request queue fills; samples hold in the queue while
// the 8-entry result queue together with work in flight would overflow.
`include "assert_macros.svh"

module deformable_bilinear_sampler_core #(
	parameter int MAX_WIDTH  = dbs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = dbs_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_KERNEL = dbs_pkg::MAX_KERNEL_DEF,
	parameter int FRAC_BITS  = dbs_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              kind,
	input  logic [6:0]                        row,
	input  logic [6:0]                        col,
	input  logic [2:0]                        tap_row,
	input  logic [2:0]                        tap_col,
	input  logic signed [15:0]                pixel_value,
	input  logic signed [15:0]                offset_rows,
	input  logic signed [15:0]                offset_cols,
	input  logic [15:0]                       mask_weight,
	input  logic                              use_mask,
	output logic                              empty,
	input  logic                              pop,
	output logic signed [15:0]                sample_value,
	output logic                              inside_res,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dbs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dbs_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int OCNT_W = $clog2(dbs_pkg::OUT_DEPTH + 1);

	dbs_pkg::config_t cfg_q;
	dbs_pkg::entry_t fe_entry, head;
	dbs_pkg::result_t out_res, out_head;
	logic fe_keep, mid_empty, mid_pop, out_push, out_full;
	logic [OCNT_W-1:0] out_cnt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_width     <= 8'd128;
			cfg_q.map_height    <= 8'd128;
			cfg_q.stride_rows   <= 4'd1;
			cfg_q.stride_cols   <= 4'd1;
			cfg_q.pad_rows      <= 4'd0;
			cfg_q.pad_cols      <= 4'd0;
			cfg_q.dilation_rows <= 4'd1;
			cfg_q.dilation_cols <= 4'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				dbs_pkg::REG_MAP_WIDTH:  cfg_q.map_width     <= cfg_data;
				dbs_pkg::REG_MAP_HEIGHT: cfg_q.map_height    <= cfg_data;
				dbs_pkg::REG_STRIDE_R:   cfg_q.stride_rows   <= cfg_data[3:0];
				dbs_pkg::REG_STRIDE_C:   cfg_q.stride_cols   <= cfg_data[3:0];
				dbs_pkg::REG_PAD_R:      cfg_q.pad_rows      <= cfg_data[3:0];
				dbs_pkg::REG_PAD_C:      cfg_q.pad_cols      <= cfg_data[3:0];
				dbs_pkg::REG_DIL_R:      cfg_q.dilation_rows <= cfg_data[3:0];
				dbs_pkg::REG_DIL_C:      cfg_q.dilation_cols <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	dbs_front #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
		.MAX_KERNEL(MAX_KERNEL), .FRAC_BITS(FRAC_BITS)
	) u_front (
		.cfg(cfg_q), .kind(kind), .row(row), .col(col),
		.tap_row(tap_row), .tap_col(tap_col), .pixel_value(pixel_value),
		.offset_rows(offset_rows), .offset_cols(offset_cols),
		.mask_weight(mask_weight), .use_mask(use_mask),
		.entry(fe_entry), .keep(fe_keep)
	);

	dbs_fifo #(.T(dbs_pkg::entry_t), .DEPTH(dbs_pkg::MID_DEPTH)) u_mid (
		.clk(clk), .arst_n(arst_n),
		.wr(push && fe_keep), .wdata(fe_entry), .full(full),
		.rd(mid_pop), .rdata(head), .empty(mid_empty), .count()
	);

	dbs_back #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .q_empty(mid_empty), .q_pop(mid_pop),
		.out_count(out_cnt), .out_push(out_push), .out_res(out_res)
	);

	dbs_fifo #(.T(dbs_pkg::result_t), .DEPTH(dbs_pkg::OUT_DEPTH)) u_out (
		.clk(clk), .arst_n(arst_n),
		.wr(out_push), .wdata(out_res), .full(out_full),
		.rd(pop), .rdata(out_head), .empty(empty), .count(out_cnt)
	);

	assign sample_value = out_head.value;
	assign inside_res   = out_head.in_box;

	`ASSERT_IMPLIES(a_out_room, out_push, !out_full)
	`ASSERT_IMPLIES(a_zero_outside, !empty && !inside_res, sample_value == 16'sd0)
	`ASSERT_NEXT(a_last_pop, pop && !empty && out_cnt == OCNT_W'(1) && !out_push, empty)

endmodule

@@ rtl/dbs_fifo.sv @@
module dbs_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr,
	input  T                           wdata,
	output logic                       full,
	input  logic                       rd,
	output T                           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH+1);

	T mem_q [DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_wr, do_rd;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign count = cnt_q;
	assign rdata = mem_q[rp_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wp_q <= wp_q + PTR_W'(1);
			if (do_rd)
				rp_q <= rp_q + PTR_W'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wp_q] <= wdata;
	end

endmodule

@@ rtl/dbs_front.sv @@
module dbs_front #(
	parameter int MAX_WIDTH  = dbs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = dbs_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_KERNEL = dbs_pkg::MAX_KERNEL_DEF,
	parameter int FRAC_BITS  = dbs_pkg::FRAC_BITS_DEF
) (
	input  dbs_pkg::config_t  cfg,
	input  logic              kind,
	input  logic [6:0]        row,
	input  logic [6:0]        col,
	input  logic [2:0]        tap_row,
	input  logic [2:0]        tap_col,
	input  logic signed [15:0] pixel_value,
	input  logic signed [15:0] offset_rows,
	input  logic signed [15:0] offset_cols,
	input  logic [15:0]       mask_weight,
	input  logic              use_mask,
	output dbs_pkg::entry_t   entry,
	output logic              keep
);

	localparam int DIM_W = dbs_pkg::DIM_W;
	localparam int PT_W  = 14 + FRAC_BITS;
	localparam logic [3:0] TAP_MAX = 4'(MAX_KERNEL - 1);
	localparam logic signed [PT_W-1:0] ONE = PT_W'(1) << FRAC_BITS;
	localparam logic signed [PT_W-1:0] NEG_ONE = -ONE;

	logic [2:0] tr, tc;
	logic [10:0] rs, cs;
	logic [6:0] tdr, tdc;
	logic signed [12:0] base_r, base_c;
	logic signed [PT_W-1:0] ph, pw, php, pwp, lim_h, lim_w;
	logic [DIM_W-1:0] mh, mw, eh, ew, hp, wp;
	logic in_box;

	assign tr = ({1'b0, tap_row} > TAP_MAX) ? TAP_MAX[2:0] : tap_row;
	assign tc = ({1'b0, tap_col} > TAP_MAX) ? TAP_MAX[2:0] : tap_col;
	assign rs  = 11'(row) * 11'(cfg.stride_rows);
	assign cs  = 11'(col) * 11'(cfg.stride_cols);
	assign tdr = 7'(tr) * 7'(cfg.dilation_rows);
	assign tdc = 7'(tc) * 7'(cfg.dilation_cols);
	assign base_r = $signed(13'(rs)) + $signed(13'(tdr)) - $signed(13'(cfg.pad_rows));
	assign base_c = $signed(13'(cs)) + $signed(13'(tdc)) - $signed(13'(cfg.pad_cols));
	assign ph = (PT_W'(base_r) <<< FRAC_BITS) + PT_W'(offset_rows);
	assign pw = (PT_W'(base_c) <<< FRAC_BITS) + PT_W'(offset_cols);

	assign mh = DIM_W'(cfg.map_height);
	assign mw = DIM_W'(cfg.map_width);
	assign eh = (mh == '0) ? DIM_W'(1) : (mh > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : mh;
	assign ew = (mw == '0) ? DIM_W'(1) : (mw > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : mw;
	assign lim_h = PT_W'($signed({1'b0, eh})) <<< FRAC_BITS;
	assign lim_w = PT_W'($signed({1'b0, ew})) <<< FRAC_BITS;

	assign in_box = (ph > NEG_ONE) && (pw > NEG_ONE) && (ph < lim_h) && (pw < lim_w);
	assign php = ph + ONE;
	assign pwp = pw + ONE;
	assign hp  = php[FRAC_BITS +: DIM_W];
	assign wp  = pwp[FRAC_BITS +: DIM_W];

	always_comb begin
		entry = '0;
		entry.is_sample = kind;
		entry.pixel     = pixel_value;
		entry.mask      = mask_weight;
		entry.use_mask  = use_mask;
		if (kind) begin
			entry.in_box = in_box;
			entry.r_idx  = hp;
			entry.c_idx  = wp;
			entry.lh     = dbs_pkg::FRAC_MAX'(php[FRAC_BITS-1:0]);
			entry.lw     = dbs_pkg::FRAC_MAX'(pwp[FRAC_BITS-1:0]);
			if (in_box) begin
				entry.nb_ok[0] = (hp != '0) && (wp != '0);
				entry.nb_ok[1] = (hp != '0) && (wp < ew);
				entry.nb_ok[2] = (hp < eh) && (wp != '0);
				entry.nb_ok[3] = (hp < eh) && (wp < ew);
			end
		end else begin
			entry.r_idx = DIM_W'(row);
			entry.c_idx = DIM_W'(col);
		end
	end

	assign keep = kind || ((DIM_W'(row) < DIM_W'(MAX_HEIGHT)) && (DIM_W'(col) < DIM_W'(MAX_WIDTH)));

endmodule

@@ rtl/dbs_back.sv @@
module dbs_back #(
	parameter int MAX_WIDTH  = dbs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = dbs_pkg::MAX_HEIGHT_DEF,
	parameter int FRAC_BITS  = dbs_pkg::FRAC_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  dbs_pkg::entry_t                          head,
	input  logic                                     q_empty,
	output logic                                     q_pop,
	input  logic [$clog2(dbs_pkg::OUT_DEPTH+1)-1:0]  out_count,
	output logic                                     out_push,
	output dbs_pkg::result_t                         out_res
);

	localparam int BH     = (MAX_HEIGHT + 1) / 2;
	localparam int BW     = (MAX_WIDTH + 1) / 2;
	localparam int BDEPTH = BH * BW;
	localparam int BA_W   = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
	localparam int W_W    = 2 * FRAC_BITS + 2;
	localparam int P_W    = W_W + 17;
	localparam int ACC_W  = P_W + 2;
	localparam int MUL_W  = ACC_W + 17;
	localparam int SH     = 2 * FRAC_BITS + dbs_pkg::MASK_FRAC;
	localparam logic [FRAC_BITS:0] ONE_F = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic signed [MUL_W-1:0] HALF   = MUL_W'(1) << (SH - 1);
	localparam logic signed [MUL_W-1:0] SAT_HI = MUL_W'(32767);
	localparam logic signed [MUL_W-1:0] SAT_LO = ~SAT_HI;

	function automatic logic [15:0] pick(input logic pr, input logic pc,
			input logic [15:0] a0, input logic [15:0] a1,
			input logic [15:0] a2, input logic [15:0] a3);
		return pr ? (pc ? a3 : a2) : (pc ? a1 : a0);
	endfunction

	logic issue_s, issue_w, credit_ok;
	logic [2:0] inflight;
	logic [BA_W-1:0] addr [4];
	logic [3:0] wen;
	logic [15:0] rd_s1 [4];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic ins_s1, ins_s2, ins_s3, ins_s4, ins_s5;
	logic hpar_s1, wpar_s1, um_s1, um_s2, um_s3, um_s4;
	logic [FRAC_BITS-1:0] lh_s1, lw_s1;
	logic [3:0] ok_s1;
	logic [15:0] mask_s1, mask_s2, mask_s3, mask_s4;
	logic [W_W-1:0] w_s2 [4];
	logic signed [15:0] pix_s2 [4];
	logic signed [P_W-1:0] prod_s3 [4];
	logic signed [ACC_W-1:0] acc_s4;
	logic signed [MUL_W-1:0] mul_s5;

	assign inflight = 3'(vld_s1) + 3'(vld_s2) + 3'(vld_s3) + 3'(vld_s4) + 3'(vld_s5);
	assign credit_ok = (32'(out_count) + 32'(inflight)) < 32'(dbs_pkg::OUT_DEPTH);
	assign issue_s = !q_empty && head.is_sample && credit_ok;
	assign issue_w = !q_empty && !head.is_sample;
	assign q_pop = issue_s || issue_w;

	always_comb begin
		logic [dbs_pkg::DIM_W-1:0] rsel, csel;
		logic [21:0] ar;
		for (int b = 0; b < 4; b++) begin
			if (head.is_sample) begin
				rsel = (head.r_idx[0] == b[1]) ? head.r_idx : head.r_idx - 1'b1;
				csel = (head.c_idx[0] == b[0]) ? head.c_idx : head.c_idx - 1'b1;
			end else begin
				rsel = head.r_idx;
				csel = head.c_idx;
			end
			ar = 22'(rsel[dbs_pkg::DIM_W-1:1]) * 22'(BW) + 22'(csel[dbs_pkg::DIM_W-1:1]);
			addr[b] = ar[BA_W-1:0];
			wen[b] = issue_w && (head.r_idx[0] == b[1]) && (head.c_idx[0] == b[0]);
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_bank
		logic [15:0] mem [BDEPTH];
		always_ff @(posedge clk) begin
			if (wen[g])
				mem[addr[g]] <= head.pixel;
			if (issue_s)
				rd_s1[g] <= mem[addr[g]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= issue_s;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		logic [FRAC_BITS:0] lhx, lwx, hh, hw;
		logic [15:0] nb [4];
		lhx = (FRAC_BITS+1)'(lh_s1);
		lwx = (FRAC_BITS+1)'(lw_s1);
		hh  = ONE_F - lhx;
		hw  = ONE_F - lwx;
		nb[0] = pick(~hpar_s1, ~wpar_s1, rd_s1[0], rd_s1[1], rd_s1[2], rd_s1[3]);
		nb[1] = pick(~hpar_s1,  wpar_s1, rd_s1[0], rd_s1[1], rd_s1[2], rd_s1[3]);
		nb[2] = pick( hpar_s1, ~wpar_s1, rd_s1[0], rd_s1[1], rd_s1[2], rd_s1[3]);
		nb[3] = pick( hpar_s1,  wpar_s1, rd_s1[0], rd_s1[1], rd_s1[2], rd_s1[3]);

		ins_s1  <= head.in_box;
		hpar_s1 <= head.r_idx[0];
		wpar_s1 <= head.c_idx[0];
		lh_s1   <= head.lh[FRAC_BITS-1:0];
		lw_s1   <= head.lw[FRAC_BITS-1:0];
		ok_s1   <= head.nb_ok;
		mask_s1 <= head.mask;
		um_s1   <= head.use_mask;

		w_s2[0] <= W_W'(hh) * W_W'(hw);
		w_s2[1] <= W_W'(hh) * W_W'(lwx);
		w_s2[2] <= W_W'(lhx) * W_W'(hw);
		w_s2[3] <= W_W'(lhx) * W_W'(lwx);
		for (int i = 0; i < 4; i++)
			pix_s2[i] <= ok_s1[i] ? $signed(nb[i]) : 16'sd0;
		ins_s2  <= ins_s1;
		mask_s2 <= mask_s1;
		um_s2   <= um_s1;

		for (int i = 0; i < 4; i++)
			prod_s3[i] <= P_W'($signed({1'b0, w_s2[i]})) * P_W'(pix_s2[i]);
		ins_s3  <= ins_s2;
		mask_s3 <= mask_s2;
		um_s3   <= um_s2;

		acc_s4 <= ACC_W'(prod_s3[0]) + ACC_W'(prod_s3[1])
			+ ACC_W'(prod_s3[2]) + ACC_W'(prod_s3[3]);
		ins_s4  <= ins_s3;
		mask_s4 <= mask_s3;
		um_s4   <= um_s3;

		mul_s5 <= um_s4 ? MUL_W'(acc_s4) * MUL_W'($signed({1'b0, mask_s4}))
			: MUL_W'(acc_s4) <<< dbs_pkg::MASK_FRAC;
		ins_s5 <= ins_s4;
	end

	// round half up, then clip to 16 bits
	always_comb begin
		logic signed [MUL_W-1:0] shr;
		shr = (mul_s5 + HALF) >>> SH;
		if (shr > SAT_HI)
			shr = SAT_HI;
		else if (shr < SAT_LO)
			shr = SAT_LO;
		out_res.value  = shr[15:0];
		out_res.in_box = ins_s5;
	end

	assign out_push = vld_s5;

endmodule
